[src/hhfp_pkg.sv]
// shared types, character codes and defaults for the header field line parser
package hhfp_pkg;

    localparam int unsigned DEFAULT_MAX_BLOCK_BYTES = 65536;
    localparam int unsigned DEFAULT_IN_DEPTH        = 4;
    localparam int unsigned DEFAULT_OUT_DEPTH       = 4;
    localparam int unsigned OFFSET_LIMIT            = 65536;
    localparam int unsigned OFF_W                   = 16;

    localparam logic [7:0] CHR_CR     = 8'h0d;
    localparam logic [7:0] CHR_LF     = 8'h0a;
    localparam logic [7:0] CHR_COLON  = 8'h3a;
    localparam logic [7:0] CHR_SP     = 8'h20;
    localparam logic [7:0] CHR_HTAB   = 8'h09;
    localparam logic [7:0] VCHAR_LO   = 8'h21;
    localparam logic [7:0] VCHAR_HI   = 8'h7e;
    localparam logic [7:0] OBS_TEXT_LO = 8'h80;

    typedef enum logic [2:0] {
        KIND_FIELD    = 3'd0,
        KIND_END      = 3'd1,
        KIND_BAD_NAME = 3'd2,
        KIND_MISMATCH = 3'd3,
        KIND_TOO_LONG = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        PH_LINE,
        PH_NAME,
        PH_VALUE,
        PH_VAL_CR,
        PH_VAL_LF,
        PH_END_CR,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic       start;
        logic       tchar;
        logic       blank;
        logic       vchar;
        logic       cr;
        logic       lf;
        logic       colon;
    } t_class;

    typedef struct packed {
        t_kind            kind;
        logic [OFF_W-1:0] name_offset;
        logic [OFF_W-1:0] name_length;
        logic [OFF_W-1:0] value_offset;
        logic [OFF_W-1:0] value_length;
        logic             folded;
        logic             last;
    } t_result;

endpackage

[src/hhfp_queue.sv]
// small register queue with two write ports and one read port
module hhfp_queue #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr0,
    input  logic [W-1:0]               i_wd0,
    input  logic                       i_wr1,
    input  logic [W-1:0]               i_wd1,
    input  logic                       i_rd,
    output logic [W-1:0]               o_rd_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic                       o_empty
);
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] wr_ptr1;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        wr_ptr1  = wrap_inc(r_wr_ptr);
        n_wr_ptr = r_wr_ptr;
        if (i_wr0 && i_wr1) begin
            n_wr_ptr = wrap_inc(wr_ptr1);
        end else if (i_wr0) begin
            n_wr_ptr = wr_ptr1;
        end
        n_rd_ptr = i_rd ? wrap_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CW'(i_wr0) + CW'(i_wr0 & i_wr1) - CW'(i_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr0) begin
            r_mem[r_wr_ptr] <= i_wd0;
        end
        if (i_wr0 && i_wr1) begin
            r_mem[wr_ptr1] <= i_wd1;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_count   = r_count;
    assign o_empty   = (r_count == '0);

endmodule

[src/hhfp_front.sv]
// byte classifier feeding the input queue
module hhfp_front (
    input  logic            i_push,
    input  logic            i_full,
    input  logic [7:0]      i_data_byte,
    input  logic            i_block_start,
    output logic            o_wr,
    output hhfp_pkg::t_class o_entry
);
    import hhfp_pkg::*;

    logic [7:0] c;

    always_comb begin
        c                 = i_data_byte;
        o_wr              = i_push && !i_full;
        o_entry.start     = i_block_start;
        o_entry.tchar     = c inside {[8'h30:8'h39], [8'h61:8'h7a], [8'h41:8'h5a],
                                      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
                                      8'h2a, 8'h2b, 8'h2d, 8'h2e, 8'h5e, 8'h5f,
                                      8'h60, 8'h7c, 8'h7e};
        o_entry.blank     = (c == CHR_SP) || (c == CHR_HTAB);
        o_entry.vchar     = (c inside {[VCHAR_LO:VCHAR_HI]}) || (c >= OBS_TEXT_LO);
        o_entry.cr        = (c == CHR_CR);
        o_entry.lf        = (c == CHR_LF);
        o_entry.colon     = (c == CHR_COLON);
    end

endmodule

[src/hhfp_back.sv]
// line parser state machine producing field and error words
module hhfp_back #(
    parameter int unsigned MAX_BLOCK_BYTES = hhfp_pkg::DEFAULT_MAX_BLOCK_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  logic              i_space,
    input  hhfp_pkg::t_class  i_entry,
    output logic              o_pop,
    output logic              o_wr0,
    output hhfp_pkg::t_result o_wd0,
    output logic              o_wr1,
    output hhfp_pkg::t_result o_wd1
);
    import hhfp_pkg::*;

    localparam int unsigned BYTE_LIMIT = (MAX_BLOCK_BYTES < OFFSET_LIMIT) ?
                                         MAX_BLOCK_BYTES : OFFSET_LIMIT;
    localparam int unsigned POS_W = $clog2(BYTE_LIMIT + 1);

    t_phase           r_phase, n_phase, s_phase, ph;
    logic [POS_W-1:0] r_pos, n_pos, s_pos;
    logic [POS_W-1:0] r_nb, n_nb, s_nb;
    logic [POS_W-1:0] r_ne, n_ne, s_ne;
    logic [POS_W-1:0] r_vb, n_vb, s_vb;
    logic [POS_W-1:0] r_ve, n_ve, s_ve;
    logic             r_vseen, n_vseen, s_vseen;
    logic             r_fold, n_fold, s_fold;
    logic             r_halted, n_halted, s_halted;
    logic             f_valid, e_valid, err, stop;
    t_kind            e_kind;
    logic [POS_W-1:0] e_off;
    t_result          f_rec, e_rec;

    assign o_pop = i_avail && i_space;

    always_comb begin
        if (i_entry.start) begin
            s_phase  = PH_LINE;
            s_pos    = '0;
            s_nb     = '0;
            s_ne     = '0;
            s_vb     = '0;
            s_ve     = '0;
            s_vseen  = 1'b0;
            s_fold   = 1'b0;
            s_halted = 1'b0;
        end else begin
            s_phase  = r_phase;
            s_pos    = r_pos;
            s_nb     = r_nb;
            s_ne     = r_ne;
            s_vb     = r_vb;
            s_ve     = r_ve;
            s_vseen  = r_vseen;
            s_fold   = r_fold;
            s_halted = r_halted;
        end

        n_phase  = r_phase;
        n_pos    = r_pos;
        n_nb     = r_nb;
        n_ne     = r_ne;
        n_vb     = r_vb;
        n_ve     = r_ve;
        n_vseen  = r_vseen;
        n_fold   = r_fold;
        n_halted = r_halted;
        f_valid  = 1'b0;
        e_valid  = 1'b0;
        e_kind   = KIND_FIELD;
        e_off    = '0;
        err      = 1'b0;
        stop     = 1'b0;
        ph       = s_phase;

        if (o_pop) begin
            n_phase  = s_phase;
            n_pos    = s_pos;
            n_nb     = s_nb;
            n_ne     = s_ne;
            n_vb     = s_vb;
            n_ve     = s_ve;
            n_vseen  = s_vseen;
            n_fold   = s_fold;
            n_halted = s_halted;
            if (!(s_halted || s_phase == PH_DONE)) begin
                if (s_pos >= POS_W'(BYTE_LIMIT)) begin
                    e_valid  = 1'b1;
                    e_kind   = KIND_TOO_LONG;
                    n_halted = 1'b1;
                end else begin
                    if (ph == PH_VAL_LF) begin
                        if (i_entry.blank) begin
                            n_fold  = 1'b1;
                            n_phase = PH_VALUE;
                            stop    = 1'b1;
                        end else begin
                            f_valid = 1'b1;
                            ph      = PH_LINE;
                            n_phase = PH_LINE;
                        end
                    end
                    if (!stop) begin
                        case (ph)
                            PH_LINE: begin
                                if (i_entry.cr) begin
                                    n_phase = PH_END_CR;
                                end else if (i_entry.tchar) begin
                                    n_nb    = s_pos;
                                    n_phase = PH_NAME;
                                end else begin
                                    err    = 1'b1;
                                    e_kind = KIND_BAD_NAME;
                                end
                            end
                            PH_NAME: begin
                                if (i_entry.colon) begin
                                    n_ne    = s_pos;
                                    n_vseen = 1'b0;
                                    n_fold  = 1'b0;
                                    n_vb    = '0;
                                    n_ve    = '0;
                                    n_phase = PH_VALUE;
                                end else if (!i_entry.tchar) begin
                                    err    = 1'b1;
                                    e_kind = KIND_MISMATCH;
                                end
                            end
                            PH_VALUE: begin
                                if (i_entry.blank) begin
                                    n_phase = PH_VALUE;
                                end else if (i_entry.cr) begin
                                    if (!s_vseen) begin
                                        n_vb = s_pos;
                                    end
                                    n_phase = PH_VAL_CR;
                                end else if (i_entry.vchar) begin
                                    if (!s_vseen) begin
                                        n_vb    = s_pos;
                                        n_vseen = 1'b1;
                                    end
                                    n_ve = s_pos + POS_W'(1);
                                end else begin
                                    err    = 1'b1;
                                    e_kind = KIND_MISMATCH;
                                end
                            end
                            PH_VAL_CR: begin
                                if (i_entry.lf) begin
                                    n_phase = PH_VAL_LF;
                                end else begin
                                    err    = 1'b1;
                                    e_kind = KIND_MISMATCH;
                                end
                            end
                            PH_END_CR: begin
                                if (i_entry.lf) begin
                                    e_valid = 1'b1;
                                    e_kind  = KIND_END;
                                    n_phase = PH_DONE;
                                end else begin
                                    err    = 1'b1;
                                    e_kind = KIND_MISMATCH;
                                end
                            end
                            default: begin
                                n_phase = ph;
                            end
                        endcase
                    end
                    if (err) begin
                        e_valid  = 1'b1;
                        e_off    = s_pos;
                        n_halted = 1'b1;
                    end else begin
                        n_pos = s_pos + POS_W'(1);
                    end
                end
            end
        end

        f_rec.kind         = KIND_FIELD;
        f_rec.name_offset  = OFF_W'(s_nb);
        f_rec.name_length  = OFF_W'(s_ne - s_nb);
        f_rec.value_offset = OFF_W'(s_vb);
        f_rec.value_length = s_vseen ? OFF_W'(s_ve - s_vb) : '0;
        f_rec.folded       = s_fold;
        f_rec.last         = !e_valid;

        e_rec.kind         = e_kind;
        e_rec.name_offset  = OFF_W'(e_off);
        e_rec.name_length  = '0;
        e_rec.value_offset = '0;
        e_rec.value_length = '0;
        e_rec.folded       = 1'b0;
        e_rec.last         = 1'b1;

        o_wr0 = f_valid || e_valid;
        o_wd0 = f_valid ? f_rec : e_rec;
        o_wr1 = f_valid && e_valid;
        o_wd1 = e_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LINE;
            r_pos    <= '0;
            r_nb     <= '0;
            r_ne     <= '0;
            r_vb     <= '0;
            r_ve     <= '0;
            r_vseen  <= 1'b0;
            r_fold   <= 1'b0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_nb     <= n_nb;
            r_ne     <= n_ne;
            r_vb     <= n_vb;
            r_ve     <= n_ve;
            r_vseen  <= n_vseen;
            r_fold   <= n_fold;
            r_halted <= n_halted;
        end
    end

`ifndef ASSERT_OFF
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(BYTE_LIMIT))
        else $error("position beyond block limit");

    a_halted_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_halted && !i_entry.start) |-> !o_wr0)
        else $error("word produced while halted");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr1 |-> (o_wd0.kind == KIND_FIELD) && !o_wd0.last && o_wd1.last)
        else $error("bad ordering of a word pair");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE && !(o_pop && i_entry.start)) |=> r_phase == PH_DONE)
        else $error("left end of fields without block start");
`endif

endmodule

[src/http_header_field_line_parser_top.sv]
// top level of the header field line parser: classifier, queues and line parser
//
//  channel  | handshake          | words
//  ---------+--------------------+-------------------------------------------
//  input    | push / full        | i_data_byte, i_block_start
//  result   | empty / pop        | o_kind, offsets, lengths, o_folded, o_last
//
// one byte a cycle sustained; the line parser handles one byte per cycle if results drain
// a byte leaves the input queue once the result queue has room for two words
// a word is written to the result queue as the byte that caused it is taken
// reset: synchronous, clears queues and parser state
// a stalled result side fills the result queue, then the input queue, then full rises
module http_header_field_line_parser_top #(
    parameter int unsigned MAX_BLOCK_BYTES = hhfp_pkg::DEFAULT_MAX_BLOCK_BYTES,
    parameter int unsigned IN_DEPTH        = hhfp_pkg::DEFAULT_IN_DEPTH,
    parameter int unsigned OUT_DEPTH       = hhfp_pkg::DEFAULT_OUT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_block_start,
    output logic                       empty,
    input  logic                       pop,
    output logic [2:0]                 o_kind,
    output logic [hhfp_pkg::OFF_W-1:0] o_name_offset,
    output logic [hhfp_pkg::OFF_W-1:0] o_name_length,
    output logic [hhfp_pkg::OFF_W-1:0] o_value_offset,
    output logic [hhfp_pkg::OFF_W-1:0] o_value_length,
    output logic                       o_folded,
    output logic                       o_last
);
    import hhfp_pkg::*;

    localparam int unsigned CLS_W = $bits(t_class);
    localparam int unsigned RES_W = $bits(t_result);
    localparam int unsigned ICW   = $clog2(IN_DEPTH + 1);
    localparam int unsigned OCW   = $clog2(OUT_DEPTH + 1);

    logic             in_wr;
    t_class           in_entry;
    logic [CLS_W-1:0] in_head;
    logic [ICW-1:0]   in_count;
    logic             in_empty;
    logic             back_pop;
    logic             wr0, wr1;
    t_result          wd0, wd1, res;
    logic [RES_W-1:0] out_head;
    logic [OCW-1:0]   out_count;
    logic             out_rd;

    hhfp_front u_front (
        .i_push        (push),
        .i_full        (full),
        .i_data_byte   (i_data_byte),
        .i_block_start (i_block_start),
        .o_wr          (in_wr),
        .o_entry       (in_entry)
    );

    hhfp_queue #(
        .W     (CLS_W),
        .DEPTH (IN_DEPTH)
    ) u_in_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr0     (in_wr),
        .i_wd0     (in_entry),
        .i_wr1     (1'b0),
        .i_wd1     ('0),
        .i_rd      (back_pop),
        .o_rd_data (in_head),
        .o_count   (in_count),
        .o_empty   (in_empty)
    );

    hhfp_back #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (!in_empty),
        .i_space (out_count <= OCW'(OUT_DEPTH - 2)),
        .i_entry (t_class'(in_head)),
        .o_pop   (back_pop),
        .o_wr0   (wr0),
        .o_wd0   (wd0),
        .o_wr1   (wr1),
        .o_wd1   (wd1)
    );

    hhfp_queue #(
        .W     (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr0     (wr0),
        .i_wd0     (wd0),
        .i_wr1     (wr1),
        .i_wd1     (wd1),
        .i_rd      (out_rd),
        .o_rd_data (out_head),
        .o_count   (out_count),
        .o_empty   (empty)
    );

    assign full           = (in_count == ICW'(IN_DEPTH));
    assign out_rd         = pop && !empty;
    assign res            = t_result'(out_head);
    assign o_kind         = res.kind;
    assign o_name_offset  = res.name_offset;
    assign o_name_length  = res.name_length;
    assign o_value_offset = res.value_offset;
    assign o_value_length = res.value_length;
    assign o_folded       = res.folded;
    assign o_last         = res.last;

endmodule
